// ===== rtl/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants of the pan/tilt servo position controller.
// ----------------------------------------------------------------------------
package ptp_pkg;

    // gains are signed q8.8
    localparam int GAIN_FRAC      = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_KP    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_KI    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_KD    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_KP   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_KI   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_KD   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_LO  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_MAX = 3'd7;

    localparam logic [15:0] ANGLE_LO_RESET  = 16'd500;
    localparam logic [15:0] ANGLE_MAX_RESET = 16'd2500;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
    } t_gains;

endpackage

// ===== rtl/ptp_axis.sv =====
// ----------------------------------------------------------------------------
// ptp_axis
// One pid axis: position, saturating error integral and previous error, with
// the whole update computed combinationally and registered when enabled.
// ----------------------------------------------------------------------------
module ptp_axis #(
    parameter int FRACTION_BITS = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_mode,
    input  logic [15:0]          i_target,
    input  ptp_pkg::t_gains      i_gains,
    input  logic [15:0]          i_angle_lo,
    input  logic [15:0]          i_angle_max,
    output logic [15:0]          o_compare
);

    localparam int PT = POSITION_BITS + FRACTION_BITS;
    localparam int TW = 16 + FRACTION_BITS;
    localparam int EW = ((TW > PT) ? TW : PT) + 1;
    localparam int SW = PT + 16;
    localparam int AW = ((SW + 18) > 66) ? (SW + 18) : 66;

    localparam logic signed [AW-1:0] SAT_MAX = AW'(64'h7FFF_FFFF_FFFF_FFFF);
    localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX;
    localparam logic signed [AW-1:0] SUM_HI  = (AW'(1) << (SW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SUM_LO  = (SW >= 64) ? -SUM_HI : -SUM_HI - AW'(1);
    localparam logic signed [AW-1:0] POS_MAX = (AW'(1) << PT) - AW'(1);

    logic [PT-1:0]        r_pos;
    logic signed [SW-1:0] r_sum;
    logic signed [EW-1:0] r_last;

    logic signed [AW-1:0]     w_tgt, w_pos, w_err, w_sum_raw, w_sum, w_diff;
    logic signed [EW-1:0]     w_err_n;
    logic signed [EW:0]       w_diff_n;
    logic signed [SW-1:0]     w_sum_n;
    logic signed [16+EW-1:0]  w_mp;
    logic signed [16+SW-1:0]  w_mi;
    logic signed [16+EW:0]    w_md;
    logic signed [AW-1:0]     w_acc1, w_acc2, w_acc3, w_corr;
    logic signed [AW-1:0]     w_lo, w_hi, w_step, w_preset, n_pos;
    logic [AW-1:0]            w_cmp_wide;

    // clamp to the signed 64-bit range less its most negative value
    function automatic logic signed [AW-1:0] sat64(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        y = x;
        if (x > SAT_MAX) y = SAT_MAX;
        if (x < SAT_MIN) y = SAT_MIN;
        return y;
    endfunction

    always_comb begin
        w_tgt     = $signed(AW'(i_target) << FRACTION_BITS);
        w_pos     = $signed(AW'(r_pos));
        w_err     = w_tgt - w_pos;
        w_err_n   = w_err[EW-1:0];

        w_sum_raw = AW'(r_sum) + w_err;
        w_sum     = w_sum_raw;
        if (w_sum_raw > SUM_HI) w_sum = SUM_HI;
        if (w_sum_raw < SUM_LO) w_sum = SUM_LO;
        w_sum_n   = w_sum[SW-1:0];

        w_diff    = w_err - AW'(r_last);
        w_diff_n  = w_diff[EW:0];

        w_mp = i_gains.kp * w_err_n;
        w_mi = i_gains.ki * w_sum_n;
        w_md = i_gains.kd * w_diff_n;

        w_acc1 = sat64(AW'(w_mp));
        w_acc2 = sat64(w_acc1 + sat64(AW'(w_mi)));
        w_acc3 = sat64(w_acc2 + sat64(AW'(w_md)));
        // floor back to the position scale
        w_corr = w_acc3 >>> ptp_pkg::GAIN_FRAC;

        w_lo   = $signed(AW'(i_angle_lo) << FRACTION_BITS);
        w_hi   = $signed(AW'(i_angle_max) << FRACTION_BITS);
        w_step = w_pos + w_corr;
        // upper limit first so the lower limit wins when the limits cross
        if (w_step > w_hi) w_step = w_hi;
        if (w_step < w_lo) w_step = w_lo;
        if (w_step > POS_MAX) w_step = POS_MAX;

        w_preset = (w_tgt > POS_MAX) ? POS_MAX : w_tgt;
        n_pos    = i_mode ? w_preset : w_step;

        w_cmp_wide = AW'(n_pos) >> FRACTION_BITS;
    end

    assign o_compare = w_cmp_wide[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_en) begin
            r_pos  <= n_pos[PT-1:0];
            r_sum  <= i_mode ? '0 : w_sum_n;
            r_last <= i_mode ? '0 : w_err_n;
        end
    end

    a_preset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_mode) |=> (r_sum == '0 && r_last == '0))
        else $error("preset left integral or previous error");

    a_step_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_mode && w_lo <= w_hi && w_hi <= POS_MAX)
        |=> ($signed(AW'(r_pos)) >= $past(w_lo) && $signed(AW'(r_pos)) <= $past(w_hi)))
        else $error("position outside angle limits after a step");

endmodule

// ===== rtl/pan_tilt_pid_servo_position_unit.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_pid_servo_position_unit
// Two-axis pid servo position controller with stream input and output.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A beat is captured in an input register,
// both axes are updated combinationally by parallel multipliers (three per
// axis) and the compare values land in an output register, so the unit
// sustains one beat per clock unless the output stalls. The state feedback
// loop (position, integral, previous error) closes combinationally. Gains and
// angle limits must be written through the configuration port only while no
// beat is in flight; the unit itself does not enforce this.
module pan_tilt_pid_servo_position_unit #(
    parameter int FRACTION_BITS = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [ptp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ptp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pan_target[15:0], tilt_target[31:16]
    input  logic        s_axis_tuser,   // mode[0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // pan_compare[15:0], tilt_compare[31:16]
);

    ptp_pkg::t_gains r_pan_gains, r_tilt_gains;
    logic [15:0]     r_angle_lo, r_angle_max;

    logic        r_in_valid;
    logic        r_in_mode;
    logic [15:0] r_in_pan, r_in_tilt;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic        w_advance;
    logic [15:0] w_pan_cmp, w_tilt_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_gains  <= '0;
            r_tilt_gains <= '0;
            r_angle_lo   <= ptp_pkg::ANGLE_LO_RESET;
            r_angle_max  <= ptp_pkg::ANGLE_MAX_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ptp_pkg::REG_PAN_KP:    r_pan_gains.kp  <= $signed(i_cfg_data);
                ptp_pkg::REG_PAN_KI:    r_pan_gains.ki  <= $signed(i_cfg_data);
                ptp_pkg::REG_PAN_KD:    r_pan_gains.kd  <= $signed(i_cfg_data);
                ptp_pkg::REG_TILT_KP:   r_tilt_gains.kp <= $signed(i_cfg_data);
                ptp_pkg::REG_TILT_KI:   r_tilt_gains.ki <= $signed(i_cfg_data);
                ptp_pkg::REG_TILT_KD:   r_tilt_gains.kd <= $signed(i_cfg_data);
                ptp_pkg::REG_ANGLE_LO:  r_angle_lo      <= i_cfg_data;
                ptp_pkg::REG_ANGLE_MAX: r_angle_max     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // compute when an input beat is held and the output register is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_pan  <= s_axis_tdata[15:0];
            r_in_tilt <= s_axis_tdata[31:16];
        end
    end

    ptp_axis #(
        .FRACTION_BITS(FRACTION_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_pan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_mode      (r_in_mode),
        .i_target    (r_in_pan),
        .i_gains     (r_pan_gains),
        .i_angle_lo  (r_angle_lo),
        .i_angle_max (r_angle_max),
        .o_compare   (w_pan_cmp)
    );

    ptp_axis #(
        .FRACTION_BITS(FRACTION_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_tilt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_mode      (r_in_mode),
        .i_target    (r_in_tilt),
        .i_gains     (r_tilt_gains),
        .i_angle_lo  (r_angle_lo),
        .i_angle_max (r_angle_max),
        .o_compare   (w_tilt_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {w_tilt_cmp, w_pan_cmp};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("computed beat not presented");

    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !w_advance) |=> !r_out_valid)
        else $error("output beat without a computed input");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_held_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> r_in_valid)
        else $error("input beat dropped while output stalled");

endmodule

// ===== dv/pan_tilt_pid_servo_position_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_pid_servo_position_unit_tb
// Self-checking bench for the two-axis pid servo unit. Setpoint beats are
// streamed in with random bursts and gaps while the output side stalls on its
// own pattern. A scoreboard class keeps a cycle-free model of both axes: it
// predicts the compare values for every accepted beat and checks each output
// beat in order. Gains and angle limits are reprogrammed between phases: a
// directed opener, randomized control runs, and a windup run in both
// directions that builds up the error integral while the position is pinned.
// ----------------------------------------------------------------------------
module pan_tilt_pid_servo_position_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 8;
    localparam int POS_BITS = 16;
    localparam int SUM_BITS = POS_BITS + FRAC_BITS + 16;
    localparam longint POS_TOP = (64'sd1 <<< (POS_BITS + FRAC_BITS)) - 64'sd1;
    localparam longint SUM_TOP = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 8;
    localparam int PHASE_BEATS = 110;
    // full-scale error piles up in the integral while the position is pinned
    localparam int WINDUP_STEPS = 60;
    localparam int MAX_REPORTS = 40;

    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_PRESET = 1'b1;

    typedef enum {CFG_GENTLE, CFG_WILD, CFG_EDGES} cfg_style_e;
    typedef enum {RX_OPEN, RX_COIN, RX_MASK, RX_STARVED} rx_style_e;

    class servo_scoreboard;
        ptp_pkg::t_gains gains[2];
        logic [15:0]     angle_lo;
        logic [15:0]     angle_hi;
        longint          position[2];
        longint          error_sum[2];
        longint          last_error[2];
        logic [31:0]     compare_q[$];
        int              mismatches;

        function new();
            gains[0] = '0;
            gains[1] = '0;
            angle_lo = ptp_pkg::ANGLE_LO_RESET;
            angle_hi = ptp_pkg::ANGLE_MAX_RESET;
            for (int a = 0; a < 2; a++) begin
                position[a] = 0;
                error_sum[a] = 0;
                last_error[a] = 0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [ptp_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic [ptp_pkg::CFG_DATA_BITS-1:0] val);
            case (idx)
                ptp_pkg::REG_PAN_KP:    gains[0].kp = val;
                ptp_pkg::REG_PAN_KI:    gains[0].ki = val;
                ptp_pkg::REG_PAN_KD:    gains[0].kd = val;
                ptp_pkg::REG_TILT_KP:   gains[1].kp = val;
                ptp_pkg::REG_TILT_KI:   gains[1].ki = val;
                ptp_pkg::REG_TILT_KD:   gains[1].kd = val;
                ptp_pkg::REG_ANGLE_LO:  angle_lo = val;
                ptp_pkg::REG_ANGLE_MAX: angle_hi = val;
                default: ;
            endcase
        endfunction

        function void advance_axis(int a, logic [15:0] target);
            longint err;
            longint sum;
            longint acc;
            longint pos;
            longint lo;
            longint hi;
            err = (longint'(target) << FRAC_BITS) - position[a];
            sum = error_sum[a] + err;
            if (sum > SUM_TOP) sum = SUM_TOP;
            if (sum < -SUM_TOP - 1) sum = -SUM_TOP - 1;
            error_sum[a] = sum;
            // largest term is ki * sum, around 2^54, so 64 bits hold the total
            acc = longint'($signed(gains[a].kp)) * err
                + longint'($signed(gains[a].ki)) * sum
                + longint'($signed(gains[a].kd)) * (err - last_error[a]);
            last_error[a] = err;
            pos = position[a] + (acc >>> ptp_pkg::GAIN_FRAC);
            lo = longint'(angle_lo) << FRAC_BITS;
            hi = longint'(angle_hi) << FRAC_BITS;
            // upper limit first so the lower one wins when they cross
            if (pos > hi) pos = hi;
            if (pos < lo) pos = lo;
            if (pos > POS_TOP) pos = POS_TOP;
            if (pos < 0) pos = 0;
            position[a] = pos;
        endfunction

        function void note_beat(logic mode, logic [15:0] pan, logic [15:0] tilt);
            logic [15:0] target[2];
            target[0] = pan;
            target[1] = tilt;
            for (int a = 0; a < 2; a++) begin
                if (mode == MODE_PRESET) begin
                    position[a] = longint'(target[a]) << FRAC_BITS;
                    error_sum[a] = 0;
                    last_error[a] = 0;
                end else begin
                    advance_axis(a, target[a]);
                end
            end
            compare_q.push_back({position[1][FRAC_BITS +: 16], position[0][FRAC_BITS +: 16]});
        endfunction

        function void report_mismatch(string msg);
            if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endfunction

        function void check_beat(logic [31:0] data);
            logic [31:0] want;
            if (compare_q.size() == 0) begin
                report_mismatch($sformatf("output beat %h with nothing pending", data));
                return;
            end
            want = compare_q.pop_front();
            if (data[15:0] !== want[15:0])
                report_mismatch($sformatf("pan_compare %h, expected %h", data[15:0], want[15:0]));
            if (data[31:16] !== want[31:16])
                report_mismatch($sformatf("tilt_compare %h, expected %h",
                                          data[31:16], want[31:16]));
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [ptp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [ptp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [31:0]                        s_axis_tdata = '0;   // pan_target[15:0], tilt_target[31:16]
    logic                               s_axis_tuser = 1'b0; // mode[0]
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [31:0]                        m_axis_tdata;        // pan_compare[15:0], tilt_compare[31:16]

    servo_scoreboard sb = new();
    int              burst_left = 0;
    int              idle_cycles = 0;
    rx_style_e       rx_style = RX_OPEN;
    int unsigned     rx_count = 0;
    logic [7:0]      rx_mask = 8'hff;

    pan_tilt_pid_servo_position_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_beat(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata);
    end

    // output backpressure in one of four styles, picked anew at random
    always @(posedge i_clk) begin
        if (rx_count % 300 == 0) begin
            rx_style = rx_style_e'($urandom_range(0, 3));
            rx_mask = 8'($urandom) | 8'h01;
        end
        rx_count++;
        case (rx_style)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            RX_MASK:  m_axis_tready <= rx_mask[rx_count[2:0]];
            default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic mode, input logic [15:0] pan, input logic [15:0] tilt);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {tilt, pan};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the sender until every predicted beat has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.compare_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ptp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [ptp_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input ptp_pkg::t_gains pan, input ptp_pkg::t_gains tilt,
                             input logic [15:0] lo, input logic [15:0] hi);
        write_reg(ptp_pkg::REG_PAN_KP, pan.kp);
        write_reg(ptp_pkg::REG_PAN_KI, pan.ki);
        write_reg(ptp_pkg::REG_PAN_KD, pan.kd);
        write_reg(ptp_pkg::REG_TILT_KP, tilt.kp);
        write_reg(ptp_pkg::REG_TILT_KI, tilt.ki);
        write_reg(ptp_pkg::REG_TILT_KD, tilt.kd);
        write_reg(ptp_pkg::REG_ANGLE_LO, lo);
        write_reg(ptp_pkg::REG_ANGLE_MAX, hi);
    endtask

    function automatic logic [15:0] pick_value(cfg_style_e st, int lo, int hi);
        logic [15:0] corners[5];
        corners = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff};
        case (st)
            CFG_GENTLE: return 16'(lo + int'($urandom_range(0, hi - lo)));
            CFG_WILD:   return 16'($urandom);
            default:    return corners[$urandom_range(0, 4)];
        endcase
    endfunction

    initial begin
        ptp_pkg::t_gains g_pan;
        ptp_pkg::t_gains g_tilt;
        ptp_pkg::t_gains ki_only;
        cfg_style_e      st;
        logic [15:0]     lim_lo;
        logic [15:0]     lim_hi;
        logic [15:0]     pan_goal;
        logic [15:0]     tilt_goal;
        int              hold;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero gains, limits 500..2500
        send_beat(MODE_STEP, 16'd0, 16'd0);
        send_beat(MODE_STEP, 16'hffff, 16'hffff);
        // preset ignores the angle limits
        send_beat(MODE_PRESET, 16'hffff, 16'd0);
        send_beat(MODE_STEP, 16'd0, 16'hffff);
        drain();

        g_pan = '{16'sh0100, 16'sh0004, 16'sh0020};
        g_tilt = '{16'sh0080, -16'sh0004, -16'sh0020};
        write_all(g_pan, g_tilt, 16'd0, 16'hffff);
        send_beat(MODE_PRESET, 16'd1000, 16'd3000);
        repeat (5) send_beat(MODE_STEP, 16'd2000, 16'd1000);
        send_beat(MODE_STEP, 16'hffff, 16'd0);
        send_beat(MODE_STEP, 16'd0, 16'hffff);
        drain();

        // gains at both ends of the range, crossed limits
        g_pan = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
        g_tilt = '{-16'sh8000, -16'sh8000, -16'sh8000};
        write_all(g_pan, g_tilt, 16'd3000, 16'd1000);
        send_beat(MODE_PRESET, 16'd0, 16'hffff);
        send_beat(MODE_STEP, 16'hffff, 16'd0);
        send_beat(MODE_STEP, 16'd0, 16'hffff);
        send_beat(MODE_STEP, 16'd2000, 16'd2000);
        send_beat(MODE_PRESET, 16'd1234, 16'd4321);
        send_beat(MODE_STEP, 16'd1234, 16'd4321);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            st = (phase % 2 == 0) ? CFG_GENTLE : ((phase % 4 == 1) ? CFG_WILD : CFG_EDGES);
            g_pan = '{pick_value(st, 32, 256), pick_value(st, 0, 8), pick_value(st, -32, 32)};
            g_tilt = '{pick_value(st, 32, 256), pick_value(st, 0, 8), pick_value(st, -32, 32)};
            lim_lo = pick_value(st, 0, 2000);
            lim_hi = (st == CFG_GENTLE) ? 16'(lim_lo + $urandom_range(100, 4000))
                                        : pick_value(st, 0, 0);
            write_all(g_pan, g_tilt, lim_lo, lim_hi);
            hold = 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_beat(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                end else begin
                    if (hold == 0) begin
                        pan_goal = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 4000));
                        tilt_goal = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 4000));
                        hold = $urandom_range(4, 24);
                        if ($urandom_range(0, 3) == 0)
                            send_beat(MODE_PRESET, 16'($urandom_range(0, 4000)),
                                      16'($urandom_range(0, 4000)));
                    end
                    hold--;
                    send_beat(MODE_STEP, pan_goal, tilt_goal);
                end
                if (phase == 4 && n == PHASE_BEATS / 2) drain();
            end
        end

        // windup upward: limits pin the position at zero, error is full scale
        drain();
        write_all('0, '0, 16'd0, 16'd0);
        send_beat(MODE_PRESET, 16'd0, 16'd0);
        repeat (WINDUP_STEPS) send_beat(MODE_STEP, 16'hffff, 16'hffff);
        drain();
        // the built-up sum alone drives the position up
        ki_only = '{16'sh0000, 16'sh0001, 16'sh0000};
        write_all(ki_only, ki_only, 16'd0, 16'hffff);
        repeat (4) send_beat(MODE_STEP, 16'd0, 16'd0);

        // windup downward from the top of the range
        drain();
        write_all('0, '0, 16'hffff, 16'hffff);
        send_beat(MODE_PRESET, 16'hffff, 16'hffff);
        repeat (WINDUP_STEPS) send_beat(MODE_STEP, 16'd0, 16'd0);
        drain();
        write_all(ki_only, ki_only, 16'd0, 16'hffff);
        repeat (4) send_beat(MODE_STEP, 16'hffff, 16'hffff);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
